// ===== hdl/zcd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, widths and constants of the zigzag current deposition block.
// Used by every module in this folder; depends on nothing.
package zcd_pkg;

  localparam int GRID_CELLS    = 1024;
  localparam int POS_FRAC_BITS = 20;

  localparam int DATA_W   = 32;
  localparam int CELL_W   = 11;
  localparam int RES_CNT  = 14;
  localparam int ADDR_W   = 5;
  localparam int MUL_W    = 33;
  localparam int PROD_W   = 2 * MUL_W;
  localparam int DISP_SH  = 54 - POS_FRAC_BITS;
  localparam int DISP_W   = POS_FRAC_BITS + 10;
  localparam int X2_W     = 33;
  localparam int XW       = ((DISP_W > X2_W) ? DISP_W : X2_W) + 1;
  localparam int FI_W     = XW - POS_FRAC_BITS;
  localparam int RW       = XW + 3;
  localparam int WT_W     = POS_FRAC_BITS + 1;
  localparam int SAT_W    = 72;
  localparam int T_W      = 33;
  localparam int Q_DEPTH  = 2;
  localparam int Q_PTR_W  = $clog2(Q_DEPTH);
  localparam int Q_CNT_W  = $clog2(Q_DEPTH + 1);

  localparam logic [WT_W-1:0] ONE_POS = WT_W'(1) << POS_FRAC_BITS;

  localparam logic [2:0] REG_CFL      = 3'd0;
  localparam logic [2:0] REG_CHARGE   = 3'd1;
  localparam logic [2:0] REG_ORIGIN_X = 3'd2;
  localparam logic [2:0] REG_ORIGIN_Y = 3'd3;
  localparam logic [2:0] REG_ORIGIN_Z = 3'd4;

  typedef struct packed {
    logic [30:0]             cfl;
    logic [DATA_W-1:0]       charge;
    logic [2:0][DATA_W-1:0]  origin;
  } cfg_t;

  typedef struct packed {
    logic [1:0][2:0][FI_W-1:0]   fi;
    logic [1:0][2:0][DATA_W-1:0] flux;
    logic [1:0][2:0][WT_W-1:0]   wt;
  } job_t;

  typedef enum logic [3:0] {
    F_IDLE, F_SUMSQ, F_ROOT, F_DIV, F_KMUL, F_DISP, F_GEOM, F_FLUX, F_PUSH
  } front_state_t;

  function automatic logic [2:0] stencil_of(input logic [2:0] p);
    logic [2:0] s;
    unique case (p)
      3'd0:    s = 3'b000;
      3'd1:    s = 3'b001;
      3'd2:    s = 3'b010;
      3'd3:    s = 3'b100;
      3'd4:    s = 3'b110;
      3'd5:    s = 3'b101;
      3'd6:    s = 3'b011;
      default: s = 3'b000;
    endcase
    return s;
  endfunction

  function automatic logic [DATA_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
    logic [DATA_W-1:0] r;
    if (v > SAT_W'(signed'(32'sh7FFFFFFF))) begin
      r = 32'h7FFFFFFF;
    end else if (v < SAT_W'(signed'(32'sh80000000))) begin
      r = 32'h80000000;
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== hdl/zcd_queue.sv =====
`timescale 1ns / 1ps
// Short queue of classified particle jobs between the front and back parts.
// Depends on zcd_pkg.
module zcd_queue import zcd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr,
  output logic full,
  input  job_t wdata,
  input  logic rd,
  output logic valid,
  output job_t rdata
);

  job_t               mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wptr;
  logic [Q_PTR_W-1:0] rptr;
  logic [Q_CNT_W-1:0] count;

  assign full  = (count == Q_CNT_W'(Q_DEPTH));
  assign valid = (count != '0);
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (wr && !full) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr && !full) begin
        wptr <= (wptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (rd && valid) begin
        rptr <= (rptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      count <= count + Q_CNT_W'(wr && !full) - Q_CNT_W'(rd && valid);
    end
  end

endmodule

// ===== hdl/zcd_front.sv =====
`timescale 1ns / 1ps
// Front part: takes particle requests, drops dead ones and computes the cells,
// fluxes and weights of both zigzag segments. Depends on zcd_pkg.
module zcd_front import zcd_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  cfg_t                     cfg,
  input  logic                     push,
  output logic                     full,
  input  logic                     particle_dead,
  input  logic signed [DATA_W-1:0] vel_x,
  input  logic signed [DATA_W-1:0] vel_y,
  input  logic signed [DATA_W-1:0] vel_z,
  input  logic signed [DATA_W-1:0] pos_x,
  input  logic signed [DATA_W-1:0] pos_y,
  input  logic signed [DATA_W-1:0] pos_z,
  output logic                     job_push,
  input  logic                     job_full,
  output job_t                     job
);

  front_state_t state;
  front_state_t state_next;

  logic                    ib_v;
  logic                    ib_dead;
  logic [2:0][DATA_W-1:0]  ib_vel;
  logic [2:0][DATA_W-1:0]  ib_pos;

  logic [2:0][DATA_W-1:0]  u;
  logic [2:0][X2_W-1:0]    x2;
  logic [2:0][XW-1:0]      x1;
  logic [63:0]             s;
  logic [35:0]             rem;
  logic [31:0]             root;
  logic [32:0]             drem;
  logic [31:0]             quot;
  logic [30:0]             k;
  logic [1:0][2:0][DATA_W-1:0] dd;
  logic [1:0]              idx;
  logic                    fe;
  logic [3:0]              cnt;

  logic                    take;
  logic signed [MUL_W-1:0] ma;
  logic signed [MUL_W-1:0] mb;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_disp;
  logic signed [PROD_W-1:0] prod_flux;
  logic signed [DISP_W-1:0] dsp;

  logic [35:0] rem_v;
  logic [31:0] root_v;
  logic [63:0] rad_v;
  logic [35:0] trial;
  logic [32:0] dv;
  logic [31:0] qv;

  logic signed [RW-1:0] xa, xb, f1, f2, lo, hi, mid, relay, d1, d2, w1, w2;

  assign full = ib_v;
  assign take = (state == F_IDLE) && ib_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      ib_v <= 1'b0;
    end else if (push && !ib_v) begin
      ib_v <= 1'b1;
    end else if (take) begin
      ib_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !ib_v) begin
      ib_dead <= particle_dead;
      ib_vel  <= {vel_z, vel_y, vel_x};
      ib_pos  <= {pos_z, pos_y, pos_x};
    end
  end

  always_comb begin
    ma = '0;
    mb = '0;
    case (state)
      F_SUMSQ: begin
        ma = MUL_W'($signed(u[idx]));
        mb = MUL_W'($signed(u[idx]));
      end
      F_KMUL: begin
        ma = $signed({2'b00, cfg.cfl});
        mb = $signed({2'b00, quot[30:0]});
      end
      F_DISP: begin
        ma = $signed({2'b00, k});
        mb = MUL_W'($signed(u[idx]));
      end
      F_FLUX: begin
        ma = MUL_W'($signed(cfg.charge));
        mb = MUL_W'($signed(dd[fe][idx]));
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign prod      = ma * mb;
  assign prod_disp = prod >>> DISP_SH;
  assign prod_flux = prod >>> POS_FRAC_BITS;
  assign dsp       = prod_disp[DISP_W-1:0];

  always_comb begin
    rem_v  = rem;
    root_v = root;
    rad_v  = s;
    for (int i = 0; i < 2; i++) begin
      rem_v = {rem_v[33:0], rad_v[63:62]};
      rad_v = {rad_v[61:0], 2'b00};
      trial = {2'b00, root_v, 2'b01};
      if (rem_v >= trial) begin
        rem_v  = rem_v - trial;
        root_v = {root_v[30:0], 1'b1};
      end else begin
        root_v = {root_v[30:0], 1'b0};
      end
    end
  end

  always_comb begin
    dv = drem;
    qv = quot;
    for (int i = 0; i < 2; i++) begin
      dv = {dv[31:0], 1'b0};
      if (dv >= {1'b0, root}) begin
        dv = dv - {1'b0, root};
        qv = {qv[30:0], 1'b1};
      end else begin
        qv = {qv[30:0], 1'b0};
      end
    end
  end

  always_comb begin
    xa    = RW'($signed(x1[idx]));
    xb    = RW'($signed(x2[idx]));
    f1    = xa >>> POS_FRAC_BITS;
    f2    = xb >>> POS_FRAC_BITS;
    lo    = (((f1 < f2) ? f1 : f2) + RW'(1)) <<< POS_FRAC_BITS;
    mid   = (xa + xb) >>> 1;
    hi    = ((f1 > f2) ? f1 : f2) <<< POS_FRAC_BITS;
    if (mid > hi) begin
      hi = mid;
    end
    relay = (lo < hi) ? lo : hi;
    d1    = relay - xa;
    d2    = xb - relay;
    w1    = ((xa + relay) >>> 1) - (f1 <<< POS_FRAC_BITS);
    w2    = ((xb + relay) >>> 1) - (f2 <<< POS_FRAC_BITS);
    if (w1 < 0) begin
      w1 = '0;
    end else if (w1 > RW'(ONE_POS)) begin
      w1 = RW'(ONE_POS);
    end
    if (w2 < 0) begin
      w2 = '0;
    end else if (w2 > RW'(ONE_POS)) begin
      w2 = RW'(ONE_POS);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    job_push   = 1'b0;
    unique case (state)
      F_IDLE:  if (ib_v) state_next = ib_dead ? F_IDLE : F_SUMSQ;
      F_SUMSQ: if (idx == 2'd2) state_next = F_ROOT;
      F_ROOT:  if (cnt == 4'd15) state_next = F_DIV;
      F_DIV:   if (cnt == 4'd15) state_next = F_KMUL;
      F_KMUL:  state_next = F_DISP;
      F_DISP:  if (idx == 2'd2) state_next = F_GEOM;
      F_GEOM:  if (idx == 2'd2) state_next = F_FLUX;
      F_FLUX:  if (idx == 2'd2 && fe) state_next = F_PUSH;
      F_PUSH: begin
        job_push = 1'b1;
        if (!job_full) state_next = F_IDLE;
      end
      default: state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      F_IDLE: begin
        idx <= '0;
        fe  <= 1'b0;
        cnt <= '0;
        s   <= 64'd1 << 48;
        u   <= ib_vel;
        for (int a = 0; a < 3; a++) begin
          x2[a] <= X2_W'($signed(ib_pos[a])) - X2_W'($signed(cfg.origin[a]));
        end
      end
      F_SUMSQ: begin
        s   <= s + prod[63:0];
        idx <= (idx == 2'd2) ? 2'd0 : idx + 1'b1;
        rem  <= '0;
        root <= '0;
      end
      F_ROOT: begin
        rem  <= rem_v;
        root <= root_v;
        s    <= rad_v;
        cnt  <= cnt + 1'b1;
        drem <= 33'd1 << 22;
        quot <= '0;
      end
      F_DIV: begin
        drem <= dv;
        quot <= qv;
        cnt  <= cnt + 1'b1;
      end
      F_KMUL: begin
        k <= prod[60:30];
      end
      F_DISP: begin
        x1[idx] <= XW'($signed(x2[idx])) - XW'(dsp);
        idx     <= (idx == 2'd2) ? 2'd0 : idx + 1'b1;
      end
      F_GEOM: begin
        job.fi[0][idx] <= f1[FI_W-1:0];
        job.fi[1][idx] <= f2[FI_W-1:0];
        job.wt[0][idx] <= w1[WT_W-1:0];
        job.wt[1][idx] <= w2[WT_W-1:0];
        dd[0][idx]     <= sat32(SAT_W'(d1));
        dd[1][idx]     <= sat32(SAT_W'(d2));
        idx            <= (idx == 2'd2) ? 2'd0 : idx + 1'b1;
      end
      F_FLUX: begin
        job.flux[fe][idx] <= sat32(SAT_W'(prod_flux));
        idx               <= (idx == 2'd2) ? 2'd0 : idx + 1'b1;
        if (idx == 2'd2) begin
          fe <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== hdl/zcd_back.sv =====
`timescale 1ns / 1ps
// Back part: walks the seven stencil offsets of both segments and multiplies
// out the fourteen current contributions of each job. Depends on zcd_pkg.
module zcd_back import zcd_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     job_valid,
  output logic                     job_pop,
  input  job_t                     job,
  input  logic                     pop,
  output logic                     empty,
  output logic [CELL_W-1:0]        cell_x,
  output logic [CELL_W-1:0]        cell_y,
  output logic [CELL_W-1:0]        cell_z,
  output logic signed [DATA_W-1:0] cur_x,
  output logic signed [DATA_W-1:0] cur_y,
  output logic signed [DATA_W-1:0] cur_z,
  output logic                     cell_out_of_range,
  output logic                     last
);

  logic [3:0]  rcnt;
  logic        en;
  logic        issue;
  logic [2:0]  st;
  logic        e;

  logic [2:0][CELL_W-1:0] c_cell;
  logic                   c_oor;
  logic [2:0][T_W-1:0]    c_t;
  logic [2:0][WT_W-1:0]   c_b;

  logic                   s1_v;
  logic [2:0][CELL_W-1:0] s1_cell;
  logic                   s1_oor;
  logic                   s1_last;
  logic [2:0][T_W-1:0]    s1_t;
  logic [2:0][WT_W-1:0]   s1_b;

  logic                   ov;
  logic [2:0][DATA_W-1:0] o_cur;
  logic [2:0][CELL_W-1:0] o_cell;

  assign en      = !ov || pop;
  assign issue   = job_valid && en;
  assign job_pop = issue && (rcnt == 4'(RES_CNT - 1));
  assign e       = rcnt[0];
  assign st      = stencil_of(rcnt[3:1]);

  always_comb begin
    logic signed [31:0]                 c32;
    logic [WT_W-1:0]                    wa;
    logic signed [DATA_W-1:0]           fl;
    logic signed [DATA_W+WT_W:0]        m1;
    int                                 b1;
    int                                 b2;
    c_oor = 1'b0;
    for (int a = 0; a < 3; a++) begin
      c32 = 32'($signed(job.fi[e][a])) + 32'(st[a]);
      if (c32 < 0) begin
        c_cell[a] = '0;
        c_oor     = 1'b1;
      end else if (c32 >= GRID_CELLS) begin
        c_cell[a] = CELL_W'(GRID_CELLS - 1);
        c_oor     = 1'b1;
      end else begin
        c_cell[a] = c32[CELL_W-1:0];
      end
      b1 = (a == 0) ? 1 : 0;
      b2 = (a == 2) ? 1 : 2;
      wa = st[b1] ? job.wt[e][b1] : ONE_POS - job.wt[e][b1];
      c_b[a] = st[b2] ? job.wt[e][b2] : ONE_POS - job.wt[e][b2];
      fl = st[a] ? '0 : $signed(job.flux[e][a]);
      m1 = fl * $signed({1'b0, wa});
      c_t[a] = T_W'(m1 >>> POS_FRAC_BITS);
    end
  end

  always_comb begin
    logic signed [T_W+WT_W:0] m2;
    for (int a = 0; a < 3; a++) begin
      m2 = $signed(s1_t[a]) * $signed({1'b0, s1_b[a]});
      o_cur[a] = DATA_W'(m2 >>> POS_FRAC_BITS);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rcnt <= '0;
      s1_v <= 1'b0;
      ov   <= 1'b0;
    end else if (en) begin
      s1_v <= issue;
      ov   <= s1_v;
      if (issue) begin
        rcnt <= (rcnt == 4'(RES_CNT - 1)) ? '0 : rcnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_cell <= c_cell;
      s1_oor  <= c_oor;
      s1_last <= (rcnt == 4'(RES_CNT - 1));
      s1_t    <= c_t;
      s1_b    <= c_b;
      o_cell  <= s1_cell;
      cur_x   <= o_cur[0];
      cur_y   <= o_cur[1];
      cur_z   <= o_cur[2];
      cell_out_of_range <= s1_oor;
      last    <= s1_last;
    end
  end

  assign empty  = !ov;
  assign cell_x = o_cell[0];
  assign cell_y = o_cell[1];
  assign cell_z = o_cell[2];

endmodule

// ===== hdl/zigzag_current_deposit.sv =====
`timescale 1ns / 1ps
// Top level of the zigzag current deposition block: configuration registers,
// front part, job queue and back part. Depends on zcd_pkg and all zcd modules.
//
// A live particle passes through the front part, whose sequencer shares one
// 33x33 multiplier and takes the square root and the reciprocal two bits per
// cycle; the back part then issues its fourteen contributions, one per cycle
// while its output is empty or being popped, as the front works on the next particle.
// A dead particle is dropped in the front and produces nothing.
// A new request is taken as soon as the one-entry input buffer is free, so
// one request can wait there while the front works on the current particle.
module zigzag_current_deposit import zcd_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ADDR_W-1:0]        paddr,
  input  logic [DATA_W-1:0]        pwdata,
  output logic [DATA_W-1:0]        prdata,
  output logic                     pready,
  input  logic                     push,
  output logic                     full,
  input  logic                     particle_dead,
  input  logic signed [DATA_W-1:0] vel_x,
  input  logic signed [DATA_W-1:0] vel_y,
  input  logic signed [DATA_W-1:0] vel_z,
  input  logic signed [DATA_W-1:0] pos_x,
  input  logic signed [DATA_W-1:0] pos_y,
  input  logic signed [DATA_W-1:0] pos_z,
  output logic                     empty,
  input  logic                     pop,
  output logic [CELL_W-1:0]        cell_x,
  output logic [CELL_W-1:0]        cell_y,
  output logic [CELL_W-1:0]        cell_z,
  output logic signed [DATA_W-1:0] cur_x,
  output logic signed [DATA_W-1:0] cur_y,
  output logic signed [DATA_W-1:0] cur_z,
  output logic                     cell_out_of_range,
  output logic                     last
);

  cfg_t cfg;
  logic wr_en;
  logic q_push;
  logic q_full;
  logic q_valid;
  logic q_pop;
  job_t q_wdata;
  job_t q_rdata;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      unique case (paddr[4:2])
        REG_CFL:      cfg.cfl       <= pwdata[30:0];
        REG_CHARGE:   cfg.charge    <= pwdata;
        REG_ORIGIN_X: cfg.origin[0] <= pwdata;
        REG_ORIGIN_Y: cfg.origin[1] <= pwdata;
        REG_ORIGIN_Z: cfg.origin[2] <= pwdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_CFL:      prdata = {1'b0, cfg.cfl};
      REG_CHARGE:   prdata = cfg.charge;
      REG_ORIGIN_X: prdata = cfg.origin[0];
      REG_ORIGIN_Y: prdata = cfg.origin[1];
      REG_ORIGIN_Z: prdata = cfg.origin[2];
      default:      prdata = '0;
    endcase
  end

  zcd_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .push          (push),
    .full          (full),
    .particle_dead (particle_dead),
    .vel_x         (vel_x),
    .vel_y         (vel_y),
    .vel_z         (vel_z),
    .pos_x         (pos_x),
    .pos_y         (pos_y),
    .pos_z         (pos_z),
    .job_push      (q_push),
    .job_full      (q_full),
    .job           (q_wdata)
  );

  zcd_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (q_push),
    .full  (q_full),
    .wdata (q_wdata),
    .rd    (q_pop),
    .valid (q_valid),
    .rdata (q_rdata)
  );

  zcd_back u_back (
    .clk               (clk),
    .rst               (rst),
    .job_valid         (q_valid),
    .job_pop           (q_pop),
    .job               (q_rdata),
    .pop               (pop),
    .empty             (empty),
    .cell_x            (cell_x),
    .cell_y            (cell_y),
    .cell_z            (cell_z),
    .cur_x             (cur_x),
    .cur_y             (cur_y),
    .cur_z             (cur_z),
    .cell_out_of_range (cell_out_of_range),
    .last              (last)
  );

`ifndef SYNTHESIS
  a_job_pop_has_entry: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid) else $error("Back part took a job from an empty queue.");

  a_job_push_has_room: assert property (@(posedge clk) disable iff (rst)
    (q_push && q_full) |=> q_push) else $error("Front part dropped a stalled job.");
`endif

endmodule
